// File: hdl/psss_pkg.sv
`default_nettype none
package psss_pkg;

  // fixed pattern storage of the block
  localparam int StoreBytes = 16;
  localparam int IdxBits    = 4;
  localparam int LenBits    = 5;

  // configuration register indexes
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] start_index;
    logic        overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SEARCH
  } back_state_t;

endpackage
`default_nettype wire

// File: hdl/psss_front.sv
`default_nettype none
module psss_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire psss_pkg::in_t in_item,
  output logic               q_valid,
  output psss_pkg::in_t      q_item,
  input  wire logic          q_pop
);
  import psss_pkg::*;

  in_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // accept while a slot is free
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule
`default_nettype wire

// File: hdl/psss_back.sv
`default_nettype none
module psss_back #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [8*psss_pkg::StoreBytes-1:0] pattern,
  input  wire logic [psss_pkg::LenBits-1:0]     eff_len,
  input  wire logic                             cfg_write,
  input  wire logic                             q_valid,
  input  wire psss_pkg::in_t                    q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output psss_pkg::out_t                        out_item
);
  import psss_pkg::*;

  localparam int PosW = POSITION_BITS + 1;
  localparam int SumW = (PosW > 16) ? PosW : 16;
  localparam logic [SumW-1:0] PosMax = {SumW{1'b1}} >> (SumW - POSITION_BITS);

  function automatic logic [7:0] pat_byte(input logic [8*StoreBytes-1:0] p,
                                          input logic [IdxBits-1:0] idx);
    pat_byte = p[8*idx +: 8];
  endfunction

  back_state_t          state, state_next;
  logic [IdxBits-1:0]   fail_tab [StoreBytes];
  logic [LenBits-1:0]   bi, bi_next;
  logic [LenBits-1:0]   bk, bk_next;
  logic [LenBits-1:0]   j, j_next;
  logic [LenBits-1:0]   matched, matched_next;
  logic [PosW-1:0]      tpos, tpos_next;
  logic                 reported, reported_next;
  logic                 tab_ready, tab_ready_next;
  logic                 out_valid_next;
  out_t                 out_item_next;

  logic [IdxBits-1:0]   rd_addr;
  logic [IdxBits-1:0]   tab_rd;
  logic                 tab_we;
  logic [IdxBits-1:0]   tab_waddr;
  logic [IdxBits-1:0]   tab_wdata;
  logic                 out_free;
  logic                 pj_eq;
  logic [LenBits-1:0]   j_adv;
  logic                 hit;
  logic [SumW-1:0]      start_w;
  logic [LenBits-1:0]   j_start;

  // single read port of the failure table
  assign rd_addr  = (state == ST_BUILD) ? (bk[IdxBits-1:0] - IdxBits'(1))
                                        : (j[IdxBits-1:0] - IdxBits'(1));
  assign tab_rd   = fail_tab[rd_addr];
  assign out_free = !out_valid || !out_stall;

  // search step values
  assign pj_eq   = (pat_byte(pattern, j[IdxBits-1:0]) == q_item.text_byte);
  assign j_adv   = j + {{(LenBits-1){1'b0}}, pj_eq};
  assign hit     = !reported && (j_adv >= eff_len);
  assign start_w = SumW'(tpos) + SumW'(1) - SumW'(eff_len);
  assign j_start = (matched >= eff_len) ? '0 : matched;

  // sequencer: table build, fallback walk and result
  always_comb begin
    state_next     = state;
    bi_next        = bi;
    bk_next        = bk;
    j_next         = j;
    matched_next   = matched;
    tpos_next      = tpos;
    reported_next  = reported;
    tab_ready_next = tab_ready;
    out_item_next  = out_item;
    out_valid_next = out_valid && out_stall;
    q_pop          = 1'b0;
    tab_we         = 1'b0;
    tab_waddr      = '0;
    tab_wdata      = '0;

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (!tab_ready) begin
            tab_we     = 1'b1;
            tab_waddr  = '0;
            tab_wdata  = '0;
            bi_next    = LenBits'(1);
            bk_next    = '0;
            state_next = ST_BUILD;
          end else begin
            j_next     = j_start;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_BUILD: begin
        if (bi >= eff_len) begin
          tab_ready_next = 1'b1;
          j_next         = j_start;
          state_next     = ST_SEARCH;
        end else if (pat_byte(pattern, bi[IdxBits-1:0]) ==
                     pat_byte(pattern, bk[IdxBits-1:0])) begin
          tab_we    = 1'b1;
          tab_waddr = bi[IdxBits-1:0];
          tab_wdata = bk[IdxBits-1:0] + IdxBits'(1);
          bk_next   = bk + LenBits'(1);
          bi_next   = bi + LenBits'(1);
        end else if (bk != '0) begin
          bk_next = {1'b0, tab_rd};
        end else begin
          tab_we    = 1'b1;
          tab_waddr = bi[IdxBits-1:0];
          tab_wdata = '0;
          bi_next   = bi + LenBits'(1);
        end
      end
      ST_SEARCH: begin
        if (!reported && (j != '0) && !pj_eq) begin
          j_next = {1'b0, tab_rd};
        end else if (out_free) begin
          q_pop      = 1'b1;
          state_next = ST_IDLE;
          if (hit) begin
            out_valid_next = 1'b1;
            out_item_next.found = 1'b1;
            if (tpos[POSITION_BITS]) begin
              out_item_next.start_index = PosMax[15:0];
              out_item_next.overflow    = 1'b1;
            end else begin
              out_item_next.start_index = start_w[15:0];
              out_item_next.overflow    = 1'b0;
            end
            reported_next = 1'b1;
            matched_next  = '0;
          end else if (!reported) begin
            matched_next = j_adv;
          end
          if (!tpos[POSITION_BITS]) tpos_next = tpos + PosW'(1);
          if (q_item.last) begin
            if (!reported && !hit) begin
              out_valid_next            = 1'b1;
              out_item_next.found       = 1'b0;
              out_item_next.start_index = '0;
              out_item_next.overflow    = 1'b0;
            end
            matched_next  = '0;
            tpos_next     = '0;
            reported_next = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // a register write forces a table rebuild
    if (cfg_write) begin
      tab_ready_next = 1'b0;
      matched_next   = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      matched   <= '0;
      tpos      <= '0;
      reported  <= 1'b0;
      tab_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      matched   <= matched_next;
      tpos      <= tpos_next;
      reported  <= reported_next;
      tab_ready <= tab_ready_next;
      out_valid <= out_valid_next;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    bi       <= bi_next;
    bk       <= bk_next;
    j        <= j_next;
    out_item <= out_item_next;
  end

  // failure table store
  always_ff @(posedge clk) begin
    if (tab_we) fail_tab[tab_waddr] <= tab_wdata;
  end

endmodule
`default_nettype wire

// File: hdl/prefix_failure_substring_search_core.sv
`default_nettype none
// Streaming first-occurrence search for a pattern of 1 to 16 bytes, one text byte
// per item, built on the prefix-failure (KMP) method. Items land in a two-entry
// queue and a sequencer works them off one at a time: a text byte passes the idle
// state and then the search state, which repeats once for each fallback step
// through the failure table and waits while the result output is stalled. Before
// the first byte after reset or a register write the table is rebuilt from the
// pattern. At most one result per text: found with the start index when the
// pattern first completes, or not found on the byte marked last. Registers sit on
// APB at byte offsets 0, 8 and 16 (64-bit data); the user must write them only
// while the block is idle, which the block itself does not enforce.
module prefix_failure_substring_search_core #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire psss_pkg::in_t  in_item,
  output logic                out_valid,
  input  wire logic           out_stall,
  output psss_pkg::out_t      out_item
);
  import psss_pkg::*;

  localparam int LenLimit = (MAX_PATTERN < StoreBytes) ? MAX_PATTERN : StoreBytes;

  logic [63:0]        pat_low;
  logic [63:0]        pat_high;
  logic [LenBits-1:0] pat_len;
  logic [LenBits-1:0] eff_len;
  logic [1:0]         reg_idx;
  logic               wr_en;
  logic               cfg_write;
  logic               q_valid;
  in_t                q_item;
  logic               q_pop;

  // register access decode
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:3];
  assign wr_en     = psel && penable && pwrite;
  assign cfg_write = wr_en && ((reg_idx == REG_PAT_LOW) || (reg_idx == REG_PAT_HIGH) ||
                               (reg_idx == REG_PAT_LEN));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= LenBits'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAT_LOW:  pat_low  <= pwdata;
        REG_PAT_HIGH: pat_high <= pwdata;
        REG_PAT_LEN:  pat_len  <= pwdata[LenBits-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_PAT_LOW:  prdata = pat_low;
      REG_PAT_HIGH: prdata = pat_high;
      REG_PAT_LEN:  prdata = {{(64-LenBits){1'b0}}, pat_len};
      default:      prdata = '0;
    endcase
  end

  // pattern length in use, clamped to one and to the storage
  always_comb begin
    if (pat_len == '0) eff_len = LenBits'(1);
    else if (pat_len > LenBits'(LenLimit)) eff_len = LenBits'(LenLimit);
    else eff_len = pat_len;
  end

  psss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  psss_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pattern   ({pat_high, pat_low}),
    .eff_len   (eff_len),
    .cfg_write (cfg_write),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: sim/tb.sv
module tb;
  import psss_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PosLimit = 1 << 16;
  localparam int HoldCycles = 500;
  localparam int DrainCycles = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_item;

  prefix_failure_substring_search_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // text bytes waiting to be offered, and search reports still due
  in_t  text_queue[$];
  out_t expected_reports[$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;

  // search model state: register copies and per-text state
  logic [63:0] pat_lo_q = '0;
  logic [63:0] pat_hi_q = '0;
  logic [4:0]  len_q = 5'd1;
  logic [3:0]  fail_tab[StoreBytes];
  logic [4:0]  match_len = '0;
  logic [16:0] text_pos = '0;
  bit          reported = 1'b0;
  bit          table_ok = 1'b0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #6000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned active_len();
    if (len_q == 0) return 1;
    if (len_q > StoreBytes) return StoreBytes;
    return len_q;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned i);
    int unsigned k;
    k = i & 15;
    if (k < 8) return pat_lo_q[8*k +: 8];
    return pat_hi_q[8*(k-8) +: 8];
  endfunction

  // longest proper prefix that is also a suffix, per pattern position
  function automatic void rebuild_failure();
    int unsigned m;
    int unsigned k;
    int unsigned i;
    m = active_len();
    k = 0;
    i = 1;
    fail_tab[0] = '0;
    while (i < m) begin
      if (pattern_byte(i) == pattern_byte(k)) begin
        k++;
        fail_tab[i] = 4'(k);
        i++;
      end else if (k != 0) begin
        k = fail_tab[k-1];
      end else begin
        fail_tab[i] = '0;
        i++;
      end
    end
    table_ok = 1'b1;
  endfunction

  function automatic void note_reg_write(input logic [1:0] idx, input logic [63:0] val);
    case (idx)
      REG_PAT_LOW:  pat_lo_q = val;
      REG_PAT_HIGH: pat_hi_q = val;
      REG_PAT_LEN:  len_q = val[4:0];
      default:      return;
    endcase
    table_ok = 1'b0;
    match_len = '0;
  endfunction

  // advance the search by one text byte; returns 1 when a report is due
  function automatic bit predict_search(input in_t it, output out_t res);
    int unsigned m;
    int unsigned j;
    bit hit;
    hit = 1'b0;
    res = '0;
    if (!table_ok) rebuild_failure();
    m = active_len();
    if (!reported) begin
      j = match_len;
      if (j >= m) j = 0;
      while (j > 0 && pattern_byte(j) != it.text_byte) j = fail_tab[j-1];
      if (pattern_byte(j) == it.text_byte) j++;
      if (j >= m) begin
        res.found = 1'b1;
        if (text_pos >= PosLimit) begin
          res.start_index = 16'hFFFF;
          res.overflow = 1'b1;
        end else begin
          res.start_index = 16'(int'(text_pos) + 1 - int'(m));
        end
        hit = 1'b1;
        reported = 1'b1;
        j = 0;
      end
      match_len = 5'(j);
    end
    if (text_pos < PosLimit) text_pos++;
    if (it.last) begin
      if (!reported) begin
        res = '0;
        hit = 1'b1;
      end
      match_len = '0;
      text_pos = '0;
      reported = 1'b0;
    end
    return hit;
  endfunction

  // item driver
  always @(posedge clk) begin : text_driver
    out_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_search(in_item, res)) expected_reports.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item <= text_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor and receiver stalls
  always @(posedge clk) begin : report_monitor
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: found=%0d start_index=%0d overflow=%0d",
                 out_item.found, out_item.start_index, out_item.overflow);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (out_item.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_item.found);
            mismatches++;
          end
          if (out_item.start_index !== want.start_index) begin
            $error("start_index: expected %0d, got %0d",
                   want.start_index, out_item.start_index);
            mismatches++;
          end
          if (out_item.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_item.overflow);
            mismatches++;
          end
        end
      end
      // long hold-off on request, else random stalls
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
        hold_served <= hold_served + 1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    note_reg_write(idx, val);
  endtask

  // wait until every item is taken and every report is in, then let the core drain
  task automatic settle();
    @(negedge clk);
    while (text_queue.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit is_last);
    in_t it;
    it.text_byte = b;
    it.last = is_last;
    text_queue.push_back(it);
  endtask

  // new random pattern, then texts built mostly from its own alphabet
  task automatic random_group(input int budget);
    logic [7:0]  alpha[3];
    logic [7:0]  b;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [58:0] junk;
    int          sent;
    int          n;
    int          m;
    int          off;
    int          pick;
    bit          embed;
    bit          close;
    for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) : alpha[$urandom_range(2)];
      hi[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) : alpha[$urandom_range(2)];
    end
    pick = $urandom_range(9);
    case (pick)
      0:       len = 5'd0;
      1:       len = 5'd16;
      2:       len = 5'd31;
      3:       len = 5'($urandom_range(17, 30));
      4:       len = 5'($urandom_range(9, 15));
      default: len = 5'($urandom_range(1, 8));
    endcase
    junk = ($urandom_range(1) == 0) ? 59'({$urandom, $urandom}) : '0;
    settle();
    reg_write(REG_PAT_LOW, lo);
    reg_write(REG_PAT_HIGH, hi);
    if ($urandom_range(3) == 0) reg_write(REG_UNUSED, {$urandom, $urandom});
    reg_write(REG_PAT_LEN, {junk, len});
    m = active_len();
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
      close = (sent + n < budget) || ($urandom_range(4) != 0);
      embed = ($urandom_range(99) < 60);
      off = (n > m) ? $urandom_range(n - m) : 0;
      for (int i = 0; i < n; i++) begin
        if (embed && i >= off && i < off + m) b = pattern_byte(i - off);
        else if ($urandom_range(4) == 0) b = 8'($urandom);
        else b = alpha[$urandom_range(2)];
        push_byte(b, close && i == n - 1);
      end
      sent += n;
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset pattern is a single zero byte
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hAA, 1'b1);

    // length zero reads as one; unused register index is ignored
    settle();
    reg_write(REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_PAT_LEN, 64'd0);
    reg_write(REG_UNUSED, 64'h0123_4567_89AB_CDEF);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b1);

    // fallback through the table: ABABC in ABABABC
    settle();
    reg_write(REG_PAT_LOW, 64'h0000_0063_6261_6261);
    reg_write(REG_PAT_HIGH, 64'd0);
    reg_write(REG_PAT_LEN, 64'd5);
    for (int i = 0; i < 6; i++) push_byte(i[0] ? 8'h62 : 8'h61, 1'b0);
    push_byte(8'h63, 1'b1);

    // register write in the middle of a text keeps the position
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    settle();
    reg_write(REG_PAT_LEN, 64'd2);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b1);

    // oversize length saturates at sixteen bytes
    settle();
    reg_write(REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_PAT_LEN, 64'd31);
    for (int i = 0; i < 16; i++) push_byte(8'hFF, i == 15);

    // random phases: receiver-heavy idling, sender-heavy idling, none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 38 : (ph == 1) ? 55 : 0;
      recv_idle = (ph == 0) ? 55 : (ph == 1) ? 38 : 0;
      for (int g = 0; g < 3; g++) begin
        if (ph == 2 && g == 0) hold_asked++;
        random_group(190);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/psss_pkg.sv
hdl/psss_front.sv
hdl/psss_back.sv
hdl/prefix_failure_substring_search_core.sv
sim/tb.sv
